// ===== sv/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and constants for the session seen hash set: payload structs,
// function and status codes, internal command codes and hash constants.
// ----------------------------------------------------------------------------
package ssh_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] item_key;
    } ssh_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [2:0] status;
        logic       accrued_reads;
    } ssh_result_t;

    // Function codes of the input transaction
    localparam logic [1:0] FUNC_TOUCH = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_TAKE  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // Status codes of the result transaction
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_ALREADY = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_FOUND   = 3'd4;
    localparam logic [2:0] ST_ABSENT  = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    // Configuration register index (word index on the APB port)
    localparam logic [0:0] REG_WRITES_ENABLED = 1'b0;
    localparam int         APB_DATA_W         = 32;

    // Classified command handed from the front end to the table engine
    typedef enum logic [2:0] {
        OP_TOUCH,
        OP_QUERY,
        OP_TAKE,
        OP_CLEAR,
        OP_IGNORE,
        OP_ABSENT
    } ssh_op_t;

    typedef struct packed {
        ssh_op_t     op;
        logic [63:0] item_key;
    } ssh_cmd_t;

    // Table engine states
    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_COMPARE,
        BK_CLEAR,
        BK_FINISH
    } ssh_bk_state_t;

    // Finalizer constants
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int          MIX_S1 = 30;
    localparam int          MIX_S2 = 27;
    localparam int          MIX_S3 = 31;

endpackage

// ===== sv/ssh_front.sv =====
// ----------------------------------------------------------------------------
// ssh_front
// Accepts input transactions, classifies them and computes the home slot
// with a five-stage finalizer pipeline built from 32x32 partial products.
// ----------------------------------------------------------------------------
module ssh_front #(
    parameter int CAPACITY = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                writes_enabled,
    input  logic                                init_busy,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ssh_pkg::ssh_item_t                  s_data,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output ssh_pkg::ssh_cmd_t                   cmd,
    output logic [$clog2(CAPACITY)-1:0]         cmd_home
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic              adv;
    logic              s_acc;
    ssh_pkg::ssh_op_t  op_in;
    logic [63:0]       p1;
    logic [63:0]       p2;
    logic [63:0]       h;

    logic [4:0]        vld_reg;

    logic [63:0]       x1_reg;
    logic [63:0]       key1_reg;
    ssh_pkg::ssh_op_t  op1_reg;

    logic [63:0]       pa_reg;
    logic [31:0]       pb_reg;
    logic [31:0]       pc_reg;
    logic [63:0]       key2_reg;
    ssh_pkg::ssh_op_t  op2_reg;

    logic [63:0]       x2_reg;
    logic [63:0]       key3_reg;
    ssh_pkg::ssh_op_t  op3_reg;

    logic [63:0]       qa_reg;
    logic [31:0]       qb_reg;
    logic [31:0]       qc_reg;
    logic [63:0]       key4_reg;
    ssh_pkg::ssh_op_t  op4_reg;

    logic [IDX_W-1:0]  home5_reg;
    logic [63:0]       key5_reg;
    ssh_pkg::ssh_op_t  op5_reg;

    // The whole pipeline holds while the last stage waits on the queue
    assign adv     = !vld_reg[4] || cmd_ready;
    assign s_ready = adv && !init_busy;
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        unique case (s_data.func)
            ssh_pkg::FUNC_TOUCH: begin
                op_in = (!writes_enabled || s_data.item_key == 64'd0) ?
                        ssh_pkg::OP_IGNORE : ssh_pkg::OP_TOUCH;
            end
            ssh_pkg::FUNC_QUERY: begin
                op_in = (s_data.item_key == 64'd0) ? ssh_pkg::OP_ABSENT : ssh_pkg::OP_QUERY;
            end
            ssh_pkg::FUNC_TAKE: begin
                op_in = (s_data.item_key == 64'd0) ? ssh_pkg::OP_ABSENT : ssh_pkg::OP_TAKE;
            end
            default: begin
                op_in = ssh_pkg::OP_CLEAR;
            end
        endcase
    end

    // Recombine the partial products: only the low 64 bits matter
    assign p1 = pa_reg + {pb_reg + pc_reg, 32'd0};
    assign p2 = qa_reg + {qb_reg + qc_reg, 32'd0};
    assign h  = p2 ^ (p2 >> ssh_pkg::MIX_S3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], s_acc};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg    <= s_data.item_key ^ (s_data.item_key >> ssh_pkg::MIX_S1);
            key1_reg  <= s_data.item_key;
            op1_reg   <= op_in;

            pa_reg    <= x1_reg[31:0] * ssh_pkg::MIX_C1[31:0];
            pb_reg    <= x1_reg[63:32] * ssh_pkg::MIX_C1[31:0];
            pc_reg    <= x1_reg[31:0] * ssh_pkg::MIX_C1[63:32];
            key2_reg  <= key1_reg;
            op2_reg   <= op1_reg;

            x2_reg    <= p1 ^ (p1 >> ssh_pkg::MIX_S2);
            key3_reg  <= key2_reg;
            op3_reg   <= op2_reg;

            qa_reg    <= x2_reg[31:0] * ssh_pkg::MIX_C2[31:0];
            qb_reg    <= x2_reg[63:32] * ssh_pkg::MIX_C2[31:0];
            qc_reg    <= x2_reg[31:0] * ssh_pkg::MIX_C2[63:32];
            key4_reg  <= key3_reg;
            op4_reg   <= op3_reg;

            home5_reg <= h[IDX_W-1:0];
            key5_reg  <= key4_reg;
            op5_reg   <= op4_reg;
        end
    end

    assign cmd_valid     = vld_reg[4];
    assign cmd.op        = op5_reg;
    assign cmd.item_key  = key5_reg;
    assign cmd_home      = home5_reg;

endmodule

// ===== sv/ssh_fifo.sv =====
// ----------------------------------------------------------------------------
// ssh_fifo
// Short command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module ssh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ===== sv/ssh_back.sv =====
// ----------------------------------------------------------------------------
// ssh_back
// Table engine: owns the key slot memory and occupancy, walks probe chains
// one slot per cycle, applies inserts and removals, sweeps the table on
// reset and on clear, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ssh_back #(
    parameter int CAPACITY = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  ssh_pkg::ssh_cmd_t            cmd,
    input  logic [$clog2(CAPACITY)-1:0]  cmd_home,
    output logic                         init_busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ssh_pkg::ssh_result_t         m_data
);

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int OCC_W      = IDX_W + 1;
    localparam int LOAD_LIMIT = (CAPACITY * 7 + 9) / 10;

    logic [63:0]              key_slots [CAPACITY];
    logic [63:0]              rdata_reg;

    ssh_pkg::ssh_bk_state_t   state_reg;
    ssh_pkg::ssh_bk_state_t   state_next;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic [IDX_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         cnt_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    ssh_pkg::ssh_op_t         op_reg;
    ssh_pkg::ssh_op_t         op_next;
    logic [63:0]              key_reg;
    logic [63:0]              key_next;
    logic                     found_reg;
    logic                     found_next;
    logic                     exh_reg;
    logic                     exh_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    ssh_pkg::ssh_result_t     m_data_reg;
    ssh_pkg::ssh_result_t     m_data_next;

    logic                     mem_we;
    logic [63:0]              mem_wdata;
    logic                     at_limit;
    ssh_pkg::ssh_result_t     res;

    assign at_limit  = (occ_reg >= OCC_W'(LOAD_LIMIT - 1));
    assign init_busy = (state_reg == ssh_pkg::BK_INIT);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        occ_next     = occ_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        found_next   = found_reg;
        exh_next     = exh_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        cmd_ready    = 1'b0;
        res          = '0;

        unique case (state_reg)
            ssh_pkg::BK_INIT: begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == '1) begin
                    state_next = ssh_pkg::BK_IDLE;
                end
            end

            ssh_pkg::BK_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    op_next  = cmd.op;
                    key_next = cmd.item_key;
                    idx_next = cmd_home;
                    cnt_next = '0;
                    unique case (cmd.op) inside
                        ssh_pkg::OP_TOUCH, ssh_pkg::OP_QUERY, ssh_pkg::OP_TAKE: begin
                            state_next = ssh_pkg::BK_COMPARE;
                        end
                        ssh_pkg::OP_CLEAR: begin
                            idx_next   = '0;
                            state_next = ssh_pkg::BK_CLEAR;
                        end
                        default: begin
                            state_next = ssh_pkg::BK_FINISH;
                        end
                    endcase
                end
            end

            ssh_pkg::BK_COMPARE: begin
                // rdata_reg holds the slot at idx_reg; hold idx on a hit or an empty slot
                if (rdata_reg == 64'd0) begin
                    found_next = 1'b0;
                    exh_next   = 1'b0;
                    state_next = ssh_pkg::BK_FINISH;
                end else if (rdata_reg == key_reg) begin
                    found_next = 1'b1;
                    exh_next   = 1'b0;
                    state_next = ssh_pkg::BK_FINISH;
                end else if (cnt_reg == '1) begin
                    found_next = 1'b0;
                    exh_next   = 1'b1;
                    state_next = ssh_pkg::BK_FINISH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ssh_pkg::BK_CLEAR: begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                occ_next = '0;
                if (idx_reg == '1) begin
                    state_next = ssh_pkg::BK_FINISH;
                end
            end

            ssh_pkg::BK_FINISH: begin
                unique case (op_reg)
                    ssh_pkg::OP_TOUCH: begin
                        if (found_reg) begin
                            res = '{status: ssh_pkg::ST_ALREADY, accrued_reads: 1'b1};
                        end else if (at_limit || exh_reg) begin
                            res = '{status: ssh_pkg::ST_DROPPED, accrued_reads: 1'b0};
                        end else begin
                            res = '{status: ssh_pkg::ST_NEW, accrued_reads: 1'b1};
                        end
                    end
                    ssh_pkg::OP_QUERY: begin
                        res = found_reg ?
                              '{status: ssh_pkg::ST_FOUND, accrued_reads: 1'b1} :
                              '{status: ssh_pkg::ST_ABSENT, accrued_reads: 1'b0};
                    end
                    ssh_pkg::OP_TAKE: begin
                        res = found_reg ?
                              '{status: ssh_pkg::ST_FOUND, accrued_reads: 1'b1} :
                              '{status: ssh_pkg::ST_ABSENT, accrued_reads: 1'b0};
                    end
                    ssh_pkg::OP_CLEAR: begin
                        res = '{status: ssh_pkg::ST_CLEARED, accrued_reads: 1'b0};
                    end
                    ssh_pkg::OP_IGNORE: begin
                        res = '{status: ssh_pkg::ST_IGNORED, accrued_reads: 1'b0};
                    end
                    default: begin
                        res = '{status: ssh_pkg::ST_ABSENT, accrued_reads: 1'b0};
                    end
                endcase

                // Commit only once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                    state_next   = ssh_pkg::BK_IDLE;
                    if (op_reg == ssh_pkg::OP_TOUCH && res.status == ssh_pkg::ST_NEW) begin
                        mem_we    = 1'b1;
                        mem_wdata = key_reg;
                        occ_next  = occ_reg + 1'b1;
                    end else if (op_reg == ssh_pkg::OP_TAKE && found_reg) begin
                        mem_we = 1'b1;
                        if (occ_reg != '0) begin
                            occ_next = occ_reg - 1'b1;
                        end
                    end
                end
            end

            default: begin
                state_next = ssh_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssh_pkg::BK_INIT;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        found_reg  <= found_next;
        exh_reg    <= exh_next;
        m_data_reg <= m_data_next;
    end

    // Slot memory: one write port at idx_reg, one registered read at idx_next
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_slots[idx_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= key_slots[idx_next];
    end

endmodule

// ===== sv/session_seen_hash_set.sv =====
// ----------------------------------------------------------------------------
// session_seen_hash_set
// Once-per-session seen set of 64-bit ids: linear probing hash table with a
// fixed capacity and a 70% load limit on inserts.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (s_valid/s_ready/s_data) carry func and item_key:
//   touch, query, take or clear. Each yields exactly one result transaction
//   (m_valid/m_ready/m_data) with status and accrued_reads, in order.
//   writes_enabled sits at APB address 0x0; write it only while idle.
// Path: five hash stages, the command queue, then the table engine, which
//   compares the probe's slots in turn and registers the result for m_valid.
// Throughput: the table engine takes one command at a time, comparing one
//   slot per cycle out of the single-read slot memory for a touch, query or
//   take; an ignored or absent item needs no probe, a clear sweeps every slot.
// Reset: the engine sweeps all CAPACITY slots to empty with s_ready low;
//   APB writes are taken throughout.
// Stall: a held result keeps the engine waiting; the command queue accepts
//   until full, then the whole hash pipeline holds and s_ready drops.
// ----------------------------------------------------------------------------
module session_seen_hash_set #(
    parameter int CAPACITY = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  ssh_pkg::ssh_item_t         s_data,

    output logic                       m_valid,
    input  logic                       m_ready,
    output ssh_pkg::ssh_result_t       m_data,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMD_W = $bits(ssh_pkg::ssh_cmd_t) + IDX_W;

    logic                 writes_enabled_reg;
    logic                 writes_enabled_next;
    logic                 init_busy;

    logic                 fr_valid;
    logic                 fr_ready;
    ssh_pkg::ssh_cmd_t    fr_cmd;
    logic [IDX_W-1:0]     fr_home;

    logic                 q_valid;
    logic                 q_ready;
    logic [CMD_W-1:0]     q_data;
    ssh_pkg::ssh_cmd_t    q_cmd;
    logic [IDX_W-1:0]     q_home;

    // APB register file: word decode on paddr[2]
    assign pready = 1'b1;

    always_comb begin
        writes_enabled_next = writes_enabled_reg;
        if (psel && penable && pwrite && paddr[2] == ssh_pkg::REG_WRITES_ENABLED) begin
            writes_enabled_next = pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ssh_pkg::REG_WRITES_ENABLED) begin
            prdata = {{(ssh_pkg::APB_DATA_W - 1){1'b0}}, writes_enabled_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            writes_enabled_reg <= 1'b1;
        end else begin
            writes_enabled_reg <= writes_enabled_next;
        end
    end

    ssh_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .writes_enabled (writes_enabled_reg),
        .init_busy      (init_busy),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .cmd_valid      (fr_valid),
        .cmd_ready      (fr_ready),
        .cmd            (fr_cmd),
        .cmd_home       (fr_home)
    );

    ssh_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   ({fr_cmd, fr_home}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_cmd  = q_data[CMD_W-1:IDX_W];
    assign q_home = q_data[IDX_W-1:0];

    ssh_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .cmd_home  (q_home),
        .init_busy (init_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for session_seen_hash_set. A local model of the probed
// key table predicts status and accrued_reads for every accepted transaction;
// directed tests cover chain breaks, wrap-around, the load limit and the
// writes_enabled register, followed by backpressure and random traffic.
// ----------------------------------------------------------------------------
module testbench;
    import ssh_pkg::*;

    localparam int          CAPACITY         = 1024;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES     = 40;
    localparam int          CYCLE_LIMIT      = 20_000_000;
    localparam int          KEY_POOL_DEPTH   = 128;
    localparam logic [2:0]  ADDR_WRITES_EN   = {REG_WRITES_ENABLED, 2'b00};
    localparam logic [2:0]  ADDR_SPARE       = 3'd4;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ssh_item_t   s_data;
    logic        m_valid;
    logic        m_ready;
    ssh_result_t m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Model of the key table
    bit [63:0]   slot_keys [CAPACITY];
    int          stored_count;
    bit          writes_on;

    ssh_result_t expected_results [$];
    logic [63:0] key_pool [$];
    int          mismatch_count;
    int          cycle_count;
    bit          steady;
    bit          hold_request;

    session_seen_hash_set #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    function automatic int home_slot(logic [63:0] k);
        logic [63:0] h;
        h = k ^ (k >> MIX_S1);
        h = h * MIX_C1;
        h = h ^ (h >> MIX_S2);
        h = h * MIX_C2;
        h = h ^ (h >> MIX_S3);
        return int'(h & 64'(CAPACITY - 1));
    endfunction

    // Walk from the home slot; pos is the matching slot, the first empty
    // slot, or CAPACITY when every slot was visited.
    function automatic bit locate_key(input logic [63:0] k, output int pos);
        int i;
        i = home_slot(k);
        for (int n = 0; n < CAPACITY; n++) begin
            if (slot_keys[i] == 64'd0) begin
                pos = i;
                return 1'b0;
            end
            if (slot_keys[i] == k) begin
                pos = i;
                return 1'b1;
            end
            i = (i + 1) % CAPACITY;
        end
        pos = CAPACITY;
        return 1'b0;
    endfunction

    function automatic ssh_result_t apply_item(ssh_item_t it);
        ssh_result_t r;
        int          pos;
        r.status        = ST_ABSENT;
        r.accrued_reads = 1'b0;
        case (it.func)
            FUNC_TOUCH: begin
                if (!writes_on || it.item_key == 64'd0) begin
                    r.status = ST_IGNORED;
                end else if (locate_key(it.item_key, pos)) begin
                    r.status        = ST_ALREADY;
                    r.accrued_reads = 1'b1;
                end else if ((stored_count + 1) * 10 >= CAPACITY * 7 || pos >= CAPACITY) begin
                    r.status = ST_DROPPED;
                end else begin
                    slot_keys[pos]  = it.item_key;
                    stored_count++;
                    r.status        = ST_NEW;
                    r.accrued_reads = 1'b1;
                end
            end
            FUNC_QUERY: begin
                if (it.item_key != 64'd0 && locate_key(it.item_key, pos)) begin
                    r.status        = ST_FOUND;
                    r.accrued_reads = 1'b1;
                end
            end
            FUNC_TAKE: begin
                // No tombstone: the slot simply goes empty
                if (it.item_key != 64'd0 && locate_key(it.item_key, pos)) begin
                    slot_keys[pos] = 64'd0;
                    if (stored_count > 0)
                        stored_count--;
                    r.status        = ST_FOUND;
                    r.accrued_reads = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                foreach (slot_keys[i])
                    slot_keys[i] = 64'd0;
                stored_count = 0;
                r.status     = ST_CLEARED;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_cycles();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_for_slot(int slot);
        logic [63:0] k;
        do
            k = fresh_key();
        while (k == 64'd0 || home_slot(k) != slot);
        return k;
    endfunction

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 || key_pool.size() == 0)
            return fresh_key();
        if (r < 85)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 92)
            return key_for_slot(home_slot(key_pool[$urandom_range(0, key_pool.size() - 1)]));
        if (r < 96)
            return 64'd0;
        case ($urandom_range(0, 2))
            0: return 64'hFFFF_FFFF_FFFF_FFFF;
            1: return 64'h1;
            default: return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] func, input logic [63:0] key);
        ssh_item_t it;
        int        gap;
        it.func     = func;
        it.item_key = key;
        gap         = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        expected_results.push_back(apply_item(it));
        if (func == FUNC_TOUCH && key != 64'd0) begin
            key_pool.push_back(key);
            if (key_pool.size() > KEY_POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 999);
        if (r < 420)
            send_item(FUNC_TOUCH, pick_key());
        else if (r < 680)
            send_item(FUNC_QUERY, pick_key());
        else if (r < 990)
            send_item(FUNC_TAKE, pick_key());
        else
            send_item(FUNC_CLEAR, fresh_key());
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (addr == ADDR_WRITES_EN)
            writes_on = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_operations();
        send_item(FUNC_TOUCH, 64'h1);
        send_item(FUNC_TOUCH, 64'h1);
        send_item(FUNC_QUERY, 64'h1);
        send_item(FUNC_QUERY, 64'h2);
        send_item(FUNC_TAKE,  64'h1);
        send_item(FUNC_TAKE,  64'h1);
        send_item(FUNC_TOUCH, 64'd0);
        send_item(FUNC_QUERY, 64'd0);
        send_item(FUNC_TAKE,  64'd0);
        send_item(FUNC_TOUCH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_TOUCH, 64'h8000_0000_0000_0000);
        send_item(FUNC_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_writes_disabled();
        logic [63:0] k;
        k = fresh_key();
        send_item(FUNC_TOUCH, k);
        wait_drained();
        write_register(ADDR_WRITES_EN, 32'hFFFF_FFFE);
        send_item(FUNC_TOUCH, k);
        send_item(FUNC_TOUCH, fresh_key());
        send_item(FUNC_QUERY, k);
        send_item(FUNC_TAKE,  k);
        send_item(FUNC_CLEAR, k);
        wait_drained();
        // Unmapped address must leave writes_enabled alone
        write_register(ADDR_SPARE, 32'h1);
        send_item(FUNC_TOUCH, k);
        wait_drained();
        write_register(ADDR_WRITES_EN, 32'h1);
        send_item(FUNC_TOUCH, k);
    endtask

    task automatic test_probe_chains();
        logic [63:0] a, b, c, w0, w1;
        int          h;
        h  = $urandom_range(0, CAPACITY - 4);
        a  = key_for_slot(h);
        b  = key_for_slot(h);
        c  = key_for_slot(h);
        send_item(FUNC_TOUCH, a);
        send_item(FUNC_TOUCH, b);
        send_item(FUNC_TOUCH, c);
        // Taking the middle key strands the last one behind an empty slot
        send_item(FUNC_TAKE,  b);
        send_item(FUNC_QUERY, c);
        send_item(FUNC_TOUCH, c);
        send_item(FUNC_QUERY, a);
        w0 = key_for_slot(CAPACITY - 1);
        w1 = key_for_slot(CAPACITY - 1);
        send_item(FUNC_TOUCH, w0);
        send_item(FUNC_TOUCH, w1);
        send_item(FUNC_QUERY, w1);
        send_item(FUNC_TAKE,  w1);
    endtask

    task automatic test_fill_to_limit();
        int n;
        n = 0;
        send_item(FUNC_CLEAR, fresh_key());
        while ((stored_count + 1) * 10 < CAPACITY * 7) begin
            if (n % 8 == 7)
                send_item(FUNC_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
            else
                send_item(FUNC_TOUCH, fresh_key());
            n++;
        end
        repeat (6) send_item(FUNC_TOUCH, fresh_key());
        repeat (6) send_item(FUNC_TOUCH, key_pool[$urandom_range(0, key_pool.size() - 1)]);
        send_item(FUNC_TAKE, key_pool[key_pool.size() - 1]);
        send_item(FUNC_TOUCH, fresh_key());
        send_item(FUNC_TOUCH, fresh_key());
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        steady       = 1'b1;
        repeat (64) send_random_item();
        steady       = 1'b0;
    endtask

    task automatic test_random_traffic();
        int count;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_register(ADDR_WRITES_EN, $urandom | 32'h1);
                    count = 280;
                end
                1: begin
                    write_register(ADDR_WRITES_EN, $urandom & 32'hFFFF_FFFE);
                    count = 120;
                end
                2: begin
                    write_register(ADDR_WRITES_EN, 32'h1);
                    count = 250;
                end
                default: begin
                    write_register(ADDR_WRITES_EN, 32'hFFFF_FFFF);
                    count = 300;
                end
            endcase
            steady = (phase == 2);
            repeat (count) send_random_item();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial begin : result_sink
        int n;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else begin
                n = idle_cycles();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        ssh_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: status %0d accrued_reads %0d",
                       m_data.status, m_data.accrued_reads);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.accrued_reads !== want.accrued_reads) begin
                    $error("accrued_reads: expected %0d, got %0d",
                           want.accrued_reads, m_data.accrued_reads);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        stored_count = 0;
        writes_on    = 1'b1;
        steady       = 1'b0;
        hold_request = 1'b0;
        mismatch_count = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_operations();
        test_writes_disabled();
        test_probe_chains();
        test_fill_to_limit();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
